FILE: rtl/core/abs_pkg.sv
// ----------------------------------------------------------------------------
// abs_pkg
// Shared types and codes for the alternating bit sender: request and result
// codes, protocol phases, controller states and the controller/datapath link.
// ----------------------------------------------------------------------------
package abs_pkg;

  // request codes
  localparam logic [1:0] REQ_DATA = 2'd0;
  localparam logic [1:0] REQ_ACK  = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;
  localparam logic [1:0] REQ_EOF  = 2'd3;

  // result kinds
  localparam logic [2:0] KIND_HDR     = 3'd0;
  localparam logic [2:0] KIND_DATA    = 3'd1;
  localparam logic [2:0] KIND_ACK_OK  = 3'd2;
  localparam logic [2:0] KIND_ACK_BAD = 3'd3;
  localparam logic [2:0] KIND_TIMEOUT = 3'd4;
  localparam logic [2:0] KIND_DONE    = 3'd5;
  localparam logic [2:0] KIND_GAVE_UP = 3'd6;
  localparam logic [2:0] KIND_BUSY    = 3'd7;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EOF_ATTEMPTS  = 1'd1;

  localparam logic [15:0] TIMEOUT_RESET  = 16'd1000;
  localparam logic [1:0]  ATTEMPTS_RESET = 2'd3;

  typedef enum logic [1:0] {
    PH_FILL      = 2'd0,
    PH_WAIT_DATA = 2'd1,
    PH_WAIT_EOF  = 2'd2,
    PH_DONE      = 2'd3
  } phase_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_EVAL = 5'b00010,
    ST_ONE  = 5'b00100,
    ST_HDR  = 5'b01000,
    ST_DATA = 5'b10000
  } ctrl_state_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       data_last;
    phase_t     phase;
    logic       ack_good;
    logic       tick_fire;
    logic       full_after;
    logic       count_zero;
    logic       tries_hit;
    logic       can_emit;
  } abs_status_t;

  typedef struct packed {
    logic       capture;
    logic       store_byte;
    logic       wait_step;
    logic       wait_clr;
    logic       seq_flip;
    logic       chunk_clr;
    logic       tries_set1;
    logic       tries_inc;
    logic       phase_we;
    phase_t     phase_val;
    logic       pend_we;
    logic [2:0] pend_kind;
    logic       pend_use_seq;
    logic       emit_one;
    logic       emit_hdr;
    logic       emit_data;
  } abs_cmd_t;

endpackage

FILE: rtl/core/abs_if.sv
// ----------------------------------------------------------------------------
// abs channel interfaces
// Request, result and configuration channels, each a valid/ready pair with
// its payload.
// ----------------------------------------------------------------------------
interface abs_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic [7:0]        data_byte;
  logic              data_last;
  logic [7:0]        ack_seq;
  logic [3:0]        ack_len;
  logic [7:0]        ack_payload_xor;
  logic signed [7:0] ack_checksum;

  modport source (output valid, req_type, data_byte, data_last, ack_seq, ack_len,
                  ack_payload_xor, ack_checksum, input ready);
  modport sink   (input valid, req_type, data_byte, data_last, ack_seq, ack_len,
                  ack_payload_xor, ack_checksum, output ready);
endinterface

interface abs_rsp_if;
  logic              valid;
  logic              ready;
  logic [2:0]        out_kind;
  logic              out_seq;
  logic [3:0]        out_len;
  logic signed [7:0] out_checksum;
  logic [7:0]        out_byte;
  logic              out_last;

  modport source (output valid, out_kind, out_seq, out_len, out_checksum, out_byte,
                  out_last, input ready);
  modport sink   (input valid, out_kind, out_seq, out_len, out_checksum, out_byte,
                  out_last, output ready);
endinterface

interface abs_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/abs_ram.sv
// ----------------------------------------------------------------------------
// abs_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module abs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 10,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/abs_ctrl.sv
// ----------------------------------------------------------------------------
// abs_ctrl
// Sender controller: takes one request, decides the protocol action from the
// datapath status, then sequences any single result or frame burst.
// ----------------------------------------------------------------------------
module abs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  abs_pkg::abs_status_t status,
  input  logic                 last_data,
  output abs_pkg::abs_cmd_t    cmd
);
  import abs_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_EVAL;
        end
      end

      ST_EVAL: begin
        state_next = ST_IDLE;
        case (status.req_type)
          REQ_DATA: begin
            if (status.phase != PH_FILL) begin
              cmd.pend_we   = 1'b1;
              cmd.pend_kind = KIND_BUSY;
              state_next    = ST_ONE;
            end else begin
              cmd.store_byte = 1'b1;
              if (status.full_after || status.data_last) begin
                cmd.pend_we   = 1'b1;
                cmd.pend_kind = KIND_HDR;
                cmd.wait_clr  = 1'b1;
                cmd.phase_we  = 1'b1;
                cmd.phase_val = PH_WAIT_DATA;
                state_next    = ST_HDR;
              end
            end
          end

          REQ_ACK: begin
            if (status.phase == PH_WAIT_DATA) begin
              cmd.pend_we = 1'b1;
              if (status.ack_good) begin
                cmd.pend_kind    = KIND_ACK_OK;
                cmd.pend_use_seq = 1'b1;
                cmd.seq_flip     = 1'b1;
                cmd.chunk_clr    = 1'b1;
                cmd.wait_clr     = 1'b1;
                cmd.phase_we     = 1'b1;
                cmd.phase_val    = PH_FILL;
                state_next       = ST_ONE;
              end else begin
                cmd.pend_kind = KIND_ACK_BAD;
                cmd.wait_clr  = 1'b1;
                state_next    = ST_HDR;
              end
            end else if (status.phase == PH_WAIT_EOF) begin
              cmd.pend_we = 1'b1;
              state_next  = ST_ONE;
              if (status.ack_good) begin
                cmd.pend_kind    = KIND_DONE;
                cmd.pend_use_seq = 1'b1;
                cmd.phase_we     = 1'b1;
                cmd.phase_val    = PH_DONE;
              end else if (status.tries_hit) begin
                cmd.pend_kind    = KIND_GAVE_UP;
                cmd.pend_use_seq = 1'b1;
                cmd.phase_we     = 1'b1;
                cmd.phase_val    = PH_DONE;
              end else begin
                cmd.pend_kind = KIND_ACK_BAD;
                cmd.tries_inc = 1'b1;
                cmd.wait_clr  = 1'b1;
              end
            end
          end

          REQ_TICK: begin
            if (status.phase == PH_WAIT_DATA || status.phase == PH_WAIT_EOF) begin
              cmd.wait_step = 1'b1;
              if (status.tick_fire) begin
                cmd.pend_we = 1'b1;
                if (status.phase == PH_WAIT_DATA) begin
                  cmd.pend_kind = KIND_TIMEOUT;
                  cmd.wait_clr  = 1'b1;
                  state_next    = ST_HDR;
                end else if (status.tries_hit) begin
                  cmd.pend_kind    = KIND_GAVE_UP;
                  cmd.pend_use_seq = 1'b1;
                  cmd.phase_we     = 1'b1;
                  cmd.phase_val    = PH_DONE;
                  state_next       = ST_ONE;
                end else begin
                  cmd.pend_kind = KIND_TIMEOUT;
                  cmd.tries_inc = 1'b1;
                  cmd.wait_clr  = 1'b1;
                  state_next    = ST_ONE;
                end
              end
            end
          end

          REQ_EOF: begin
            if (status.phase == PH_FILL) begin
              cmd.pend_we   = 1'b1;
              cmd.pend_kind = KIND_HDR;
              cmd.wait_clr  = 1'b1;
              cmd.phase_we  = 1'b1;
              if (!status.count_zero) begin
                // pending bytes go out first, the eof request is dropped
                cmd.phase_val = PH_WAIT_DATA;
                state_next    = ST_HDR;
              end else begin
                cmd.tries_set1 = 1'b1;
                cmd.phase_val  = PH_WAIT_EOF;
                state_next     = ST_ONE;
              end
            end else if (status.phase != PH_DONE) begin
              cmd.pend_we   = 1'b1;
              cmd.pend_kind = KIND_BUSY;
              state_next    = ST_ONE;
            end
          end

          default: state_next = ST_IDLE;
        endcase
      end

      ST_ONE: begin
        if (status.can_emit) begin
          cmd.emit_one = 1'b1;
          state_next   = ST_IDLE;
        end
      end

      ST_HDR: begin
        if (status.can_emit) begin
          cmd.emit_hdr = 1'b1;
          state_next   = status.count_zero ? ST_IDLE : ST_DATA;
        end
      end

      ST_DATA: begin
        if (status.can_emit) begin
          cmd.emit_data = 1'b1;
          state_next    = last_data ? ST_IDLE : ST_DATA;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

endmodule

FILE: rtl/core/abs_dp.sv
// ----------------------------------------------------------------------------
// abs_dp
// Sender datapath: request capture, chunk store, running xor, sequence bit,
// phase, tick and retry counters, configuration registers and result register.
// ----------------------------------------------------------------------------
module abs_dp #(
  parameter int unsigned CHUNK_BYTES = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  abs_req_if.sink              req,
  abs_rsp_if.source            rsp,
  abs_cfg_if.sink              cfg,
  input  abs_pkg::abs_cmd_t    cmd,
  output abs_pkg::abs_status_t status,
  output logic                 last_data
);
  import abs_pkg::*;

  localparam int unsigned CW = $clog2(CHUNK_BYTES + 1);
  localparam int unsigned IW = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;

  // captured request
  logic [1:0]  req_type_q;
  logic [7:0]  data_byte_q;
  logic        data_last_q;
  logic [7:0]  ack_seq_q;
  logic [3:0]  ack_len_q;
  logic [7:0]  ack_xor_q;
  logic [7:0]  ack_cks_q;

  logic [CW-1:0] chunk_count;
  logic [7:0]    running_xor;
  logic          seq_bit;
  phase_t        phase;
  logic [15:0]   wait_ticks;
  logic [1:0]    eof_tries;
  logic [15:0]   timeout_ticks;
  logic [1:0]    eof_attempts;
  logic [2:0]    pend_kind;
  logic          pend_seq;
  logic [IW-1:0] idx, idx_next;
  logic [7:0]    ram_rdata;

  logic [CW+7:0] count_wide;
  logic [7:0]    frame_cks;
  logic [15:0]   wait_inc;
  logic [1:0]    attempt_lim;
  logic          out_valid;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_type_q  <= req.req_type;
      data_byte_q <= req.data_byte;
      data_last_q <= req.data_last;
      ack_seq_q   <= req.ack_seq;
      ack_len_q   <= req.ack_len;
      ack_xor_q   <= req.ack_payload_xor;
      ack_cks_q   <= req.ack_checksum;
    end
  end

  // configuration
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
      eof_attempts  <= ATTEMPTS_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_TIMEOUT_TICKS: timeout_ticks <= cfg.data;
        REG_EOF_ATTEMPTS:  eof_attempts  <= cfg.data[1:0];
        default:           ;
      endcase
    end
  end

  // chunk store
  abs_ram #(
    .WIDTH (8),
    .DEPTH (CHUNK_BYTES),
    .AW    (IW)
  ) u_store (
    .clk   (clk),
    .we    (cmd.store_byte),
    .waddr (chunk_count[IW-1:0]),
    .wdata (data_byte_q),
    .raddr (idx_next),
    .rdata (ram_rdata)
  );

  // replay index runs one step ahead so read data lines up with idx
  always_comb begin
    idx_next = idx;
    if (cmd.emit_hdr) begin
      idx_next = '0;
    end else if (cmd.emit_data) begin
      idx_next = idx + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_count <= '0;
      running_xor <= '0;
      seq_bit     <= 1'b0;
      phase       <= PH_FILL;
      wait_ticks  <= '0;
      eof_tries   <= '0;
    end else begin
      if (cmd.chunk_clr) begin
        chunk_count <= '0;
        running_xor <= '0;
      end else if (cmd.store_byte) begin
        chunk_count <= chunk_count + CW'(1);
        running_xor <= running_xor ^ data_byte_q;
      end
      if (cmd.seq_flip) begin
        seq_bit <= ~seq_bit;
      end
      if (cmd.phase_we) begin
        phase <= cmd.phase_val;
      end
      if (cmd.wait_clr) begin
        wait_ticks <= '0;
      end else if (cmd.wait_step) begin
        wait_ticks <= wait_inc;
      end
      if (cmd.tries_set1) begin
        eof_tries <= 2'd1;
      end else if (cmd.tries_inc) begin
        eof_tries <= eof_tries + 2'd1;
      end
    end
  end

  // pending result descriptor
  always_ff @(posedge clk) begin
    if (cmd.pend_we) begin
      pend_kind <= cmd.pend_kind;
      pend_seq  <= cmd.pend_use_seq ? seq_bit : 1'b0;
    end
  end

  // status
  assign count_wide  = (CW + 8)'(chunk_count);
  assign frame_cks   = running_xor ^ {7'd0, seq_bit} ^ count_wide[7:0];
  assign wait_inc    = wait_ticks + 16'd1;
  assign attempt_lim = (eof_attempts == 2'd0) ? 2'd1 : eof_attempts;
  assign last_data   = ((CW'(idx) + CW'(1)) == chunk_count);

  always_comb begin
    status.req_type   = req_type_q;
    status.data_last  = data_last_q;
    status.phase      = phase;
    status.ack_good   = ((ack_seq_q ^ {4'd0, ack_len_q} ^ ack_xor_q) == ack_cks_q)
                        && (ack_seq_q == {7'd0, seq_bit});
    // a wrapped counter fires as well
    status.tick_fire  = (wait_inc >= timeout_ticks) || (wait_inc == 16'd0);
    status.full_after = ((chunk_count + CW'(1)) >= CW'(CHUNK_BYTES));
    status.count_zero = (chunk_count == '0);
    status.tries_hit  = (eof_tries >= attempt_lim);
    status.can_emit   = !out_valid || rsp.ready;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_one || cmd.emit_hdr || cmd.emit_data) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_one) begin
      rsp.out_kind     <= pend_kind;
      rsp.out_seq      <= pend_seq;
      rsp.out_len      <= '0;
      rsp.out_checksum <= '0;
      rsp.out_byte     <= '0;
      rsp.out_last     <= 1'b1;
    end else if (cmd.emit_hdr) begin
      rsp.out_kind     <= pend_kind;
      rsp.out_seq      <= seq_bit;
      rsp.out_len      <= count_wide[3:0];
      rsp.out_checksum <= frame_cks;
      rsp.out_byte     <= '0;
      rsp.out_last     <= status.count_zero;
    end else if (cmd.emit_data) begin
      rsp.out_kind     <= KIND_DATA;
      rsp.out_seq      <= seq_bit;
      rsp.out_len      <= count_wide[3:0];
      rsp.out_checksum <= frame_cks;
      rsp.out_byte     <= ram_rdata;
      rsp.out_last     <= last_data;
    end
  end

  assign rsp.valid = out_valid;

endmodule

FILE: rtl/core/alternating_bit_sender.sv
// ----------------------------------------------------------------------------
// alternating_bit_sender
// Stop-and-wait sender: gathers file bytes into a chunk, sends header and
// data beats, then resends on a bad ack or timeout until the ack comes back.
//
//   channel  dir  beat
//   req      in   one request: data byte, ack, tick or end of file
//   rsp      out  one result: header, data byte or status
//   cfg      in   one register write: timeout_ticks (0), eof_attempts (1)
//
// a request is taken in one cycle and decided in the next; a result beat
// leaves the output register each cycle the sink takes it
// a frame is a header beat and its data beats, replayed from the chunk ram
// req.ready is high only between requests; cfg.ready is always high
// a stalled rsp holds its beat and pauses the replay
// reset clears state, counters and config; the chunk ram is not cleared
// ----------------------------------------------------------------------------
module alternating_bit_sender #(
  parameter int unsigned CHUNK_BYTES = 10
) (
  input  logic      clk,
  input  logic      rst,
  abs_req_if.sink   req,
  abs_rsp_if.source rsp,
  abs_cfg_if.sink   cfg
);
  import abs_pkg::*;

  abs_cmd_t    cmd;
  abs_status_t status;
  logic        last_data;

  abs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .status    (status),
    .last_data (last_data),
    .cmd       (cmd)
  );

  abs_dp #(
    .CHUNK_BYTES (CHUNK_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .cfg       (cfg),
    .cmd       (cmd),
    .status    (status),
    .last_data (last_data)
  );

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the alternating bit sender. Requests are driven
// with random gaps. A model of the sender predicts every result beat, and
// each beat taken from the block is compared field by field with the oldest
// prediction. Tests run in turn: directed corner cases, random frame traffic
// under several timeout settings, a long output stall, and a closing
// end-of-file exchange.
// ----------------------------------------------------------------------------
module tb;
  import abs_pkg::*;

  localparam int CHUNK_BYTES     = 10;
  localparam int SETTLE_CYCLES   = 8;
  localparam int WATCHDOG_CYCLES = 5000;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] data_byte;
    logic       data_last;
    logic [7:0] ack_seq;
    logic [3:0] ack_len;
    logic [7:0] ack_payload_xor;
    logic [7:0] ack_checksum;
  } req_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       seq;
    logic [3:0] len;
    logic [7:0] cks;
    logic [7:0] data;
    logic       last;
  } beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  abs_req_if req ();
  abs_rsp_if rsp ();
  abs_cfg_if cfg ();

  alternating_bit_sender #(.CHUNK_BYTES(CHUNK_BYTES)) dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  always #6 clk = ~clk;

  // sender model state
  logic [7:0]  chunk_mem [CHUNK_BYTES];
  logic [3:0]  fill_count;
  logic [7:0]  fill_xor;
  logic        seq_now;
  phase_t      ph;
  logic [15:0] ticks_waited;
  logic [1:0]  eof_sends;
  logic [15:0] cfg_timeout;
  logic [1:0]  cfg_attempts;

  beat_t step_beats [$];
  beat_t beats_due [$];

  int errors     = 0;
  int items_sent = 0;

  // traffic shaping; the rsp_ flags are shared with the receiver process
  bit req_steady  = 1'b0;
  bit rsp_steady  = 1'b0;
  int rsp_hold    = 0;
  bit rsp_holding = 1'b0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // ---------------------------------------------------------------- model

  function automatic void add_beat(logic [2:0] kind, logic seq, logic [3:0] len,
                                   logic [7:0] cks, logic [7:0] data);
    beat_t b;
    b.kind = kind;
    b.seq  = seq;
    b.len  = len;
    b.cks  = cks;
    b.data = data;
    b.last = 1'b0;
    step_beats.push_back(b);
  endfunction

  function automatic void replay_chunk(logic [2:0] lead_kind);
    logic [7:0] cks;
    int i;
    cks = fill_xor ^ {7'b0, seq_now} ^ {4'b0, fill_count};
    add_beat(lead_kind, seq_now, fill_count, cks, 8'h00);
    for (i = 0; i < fill_count; i++)
      add_beat(KIND_DATA, seq_now, fill_count, cks, chunk_mem[i]);
    ticks_waited = '0;
  endfunction

  function automatic void eof_retry(logic [2:0] lead_kind);
    logic [1:0] limit;
    limit = (cfg_attempts == 2'd0) ? 2'd1 : cfg_attempts;
    if (eof_sends >= limit) begin
      add_beat(KIND_GAVE_UP, seq_now, 4'd0, 8'd0, 8'd0);
      ph = PH_DONE;
    end else begin
      eof_sends = eof_sends + 2'd1;
      add_beat(lead_kind, 1'b0, 4'd0, 8'd0, 8'd0);
      ticks_waited = '0;
    end
  endfunction

  function automatic void predict_sender(req_item_t it);
    logic  good;
    beat_t last_beat;
    step_beats.delete();
    good = ((it.ack_seq ^ {4'b0, it.ack_len} ^ it.ack_payload_xor) == it.ack_checksum)
           && (it.ack_seq == {7'b0, seq_now});
    case (it.req_type)
      REQ_DATA: begin
        if (ph != PH_FILL) begin
          add_beat(KIND_BUSY, 1'b0, 4'd0, 8'd0, 8'd0);
        end else begin
          if (fill_count < CHUNK_BYTES) begin
            chunk_mem[fill_count] = it.data_byte;
            fill_count = fill_count + 4'd1;
            fill_xor = fill_xor ^ it.data_byte;
          end
          if (fill_count >= CHUNK_BYTES || it.data_last) begin
            replay_chunk(KIND_HDR);
            ph = PH_WAIT_DATA;
          end
        end
      end
      REQ_ACK: begin
        if (ph == PH_WAIT_DATA) begin
          if (good) begin
            add_beat(KIND_ACK_OK, seq_now, 4'd0, 8'd0, 8'd0);
            seq_now = ~seq_now;
            fill_count = '0;
            fill_xor = '0;
            ticks_waited = '0;
            ph = PH_FILL;
          end else begin
            replay_chunk(KIND_ACK_BAD);
          end
        end else if (ph == PH_WAIT_EOF) begin
          if (good) begin
            add_beat(KIND_DONE, seq_now, 4'd0, 8'd0, 8'd0);
            ph = PH_DONE;
          end else begin
            eof_retry(KIND_ACK_BAD);
          end
        end
      end
      REQ_TICK: begin
        if (ph == PH_WAIT_DATA || ph == PH_WAIT_EOF) begin
          ticks_waited = ticks_waited + 16'd1;
          // a zero timeout fires on every tick
          if (ticks_waited >= cfg_timeout || ticks_waited == 16'd0) begin
            if (ph == PH_WAIT_DATA) replay_chunk(KIND_TIMEOUT);
            else eof_retry(KIND_TIMEOUT);
          end
        end
      end
      default: begin
        if (ph == PH_FILL) begin
          // pending bytes go out as a data frame and the eof is dropped
          if (fill_count != 4'd0) begin
            replay_chunk(KIND_HDR);
            ph = PH_WAIT_DATA;
          end else begin
            eof_sends = 2'd1;
            add_beat(KIND_HDR, 1'b0, 4'd0, 8'd0, 8'd0);
            ticks_waited = '0;
            ph = PH_WAIT_EOF;
          end
        end else if (ph != PH_DONE) begin
          add_beat(KIND_BUSY, 1'b0, 4'd0, 8'd0, 8'd0);
        end
      end
    endcase
    if (step_beats.size() != 0) begin
      last_beat = step_beats.pop_back();
      last_beat.last = 1'b1;
      step_beats.push_back(last_beat);
    end
    foreach (step_beats[i]) beats_due.push_back(step_beats[i]);
  endfunction

  // ---------------------------------------------------------------- items

  function automatic req_item_t rand_item(logic [1:0] kind);
    req_item_t it;
    it.req_type        = kind;
    it.data_byte       = 8'($urandom);
    it.data_last       = 1'($urandom);
    it.ack_seq         = 8'($urandom);
    it.ack_len         = 4'($urandom);
    it.ack_payload_xor = 8'($urandom);
    it.ack_checksum    = 8'($urandom);
    return it;
  endfunction

  function automatic req_item_t mk_ack(logic [7:0] seq, logic [3:0] len, logic [7:0] pxor);
    req_item_t it;
    it = rand_item(REQ_ACK);
    it.ack_seq         = seq;
    it.ack_len         = len;
    it.ack_payload_xor = pxor;
    it.ack_checksum    = seq ^ {4'b0, len} ^ pxor;
    return it;
  endfunction

  function automatic req_item_t mk_good_ack();
    return mk_ack({7'b0, seq_now}, 4'($urandom), 8'($urandom));
  endfunction

  function automatic req_item_t mk_bad_ack();
    req_item_t  it;
    logic [7:0] s;
    if ($urandom_range(0, 1) == 1) begin
      it = mk_good_ack();
      it.ack_checksum = it.ack_checksum ^ 8'($urandom_range(1, 255));
    end else begin
      s = 8'($urandom);
      if (s == {7'b0, seq_now}) s = s ^ 8'h01;
      it = mk_ack(s, 4'($urandom), 8'($urandom));
      if ($urandom_range(0, 3) == 0) it.ack_checksum = 8'($urandom);
    end
    return it;
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic send_item(req_item_t it);
    int gap;
    gap = req_steady ? 0 : pick_gap();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.req_type        <= it.req_type;
    req.data_byte       <= it.data_byte;
    req.data_last       <= it.data_last;
    req.ack_seq         <= it.ack_seq;
    req.ack_len         <= it.ack_len;
    req.ack_payload_xor <= it.ack_payload_xor;
    req.ack_checksum    <= it.ack_checksum;
    req.valid           <= 1'b1;
    do @(posedge clk); while (req.ready !== 1'b1);
    // acks and ticks while filling are ignored and not counted
    if (!(ph == PH_FILL && (it.req_type == REQ_ACK || it.req_type == REQ_TICK)))
      items_sent++;
    predict_sender(it);
  endtask

  task automatic drain_results();
    req.valid <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
    drain_results();
    cfg.index <= idx;
    cfg.data  <= value;
    cfg.valid <= 1'b1;
    do @(posedge clk); while (cfg.ready !== 1'b1);
    cfg.valid <= 1'b0;
    if (idx == REG_TIMEOUT_TICKS) cfg_timeout = value;
    else cfg_attempts = value[1:0];
  endtask

  // answer an outstanding frame with ticks, acks and busy traffic until it
  // leaves the given phase
  task automatic exercise_wait(phase_t waiting);
    int r;
    while (ph == waiting) begin
      r = $urandom_range(0, 99);
      if (r < 22) send_item(mk_good_ack());
      else if (r < 52) send_item(rand_item(REQ_TICK));
      else if (r < 75) send_item(mk_bad_ack());
      else if (r < 88) send_item(rand_item(REQ_DATA));
      else send_item(rand_item(REQ_EOF));
    end
  endtask

  task automatic send_frame();
    int        len;
    bit        close_eof;
    int        i;
    req_item_t it;
    len = ($urandom_range(0, 4) == 0) ? CHUNK_BYTES : $urandom_range(1, CHUNK_BYTES);
    close_eof = (len < CHUNK_BYTES) && ($urandom_range(0, 3) == 0);
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 11) == 0)
        send_item(($urandom_range(0, 1) == 1) ? mk_good_ack() : rand_item(REQ_TICK));
      it = rand_item(REQ_DATA);
      if (i < len - 1 || close_eof) it.data_last = 1'b0;
      else if (len < CHUNK_BYTES) it.data_last = 1'b1;
      send_item(it);
    end
    if (close_eof) send_item(rand_item(REQ_EOF));
    exercise_wait(PH_WAIT_DATA);
  endtask

  task automatic run_traffic(int target);
    int start;
    start = items_sent;
    while (items_sent - start < target) begin
      req_steady = ($urandom_range(0, 4) == 0);
      rsp_steady = ($urandom_range(0, 4) == 0);
      send_frame();
    end
    req_steady = 1'b0;
    rsp_steady = 1'b0;
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_directed();
    req_item_t it;
    int        i;
    // ack and tick while filling give nothing
    send_item(mk_good_ack());
    send_item(rand_item(REQ_TICK));
    it = rand_item(REQ_DATA);
    it.data_byte = 8'h00;
    it.data_last = 1'b0;
    send_item(it);
    it.data_byte = 8'hFF;
    it.data_last = 1'b1;
    send_item(it);
    // busy rejects while the frame is out
    send_item(rand_item(REQ_DATA));
    send_item(rand_item(REQ_EOF));
    // bad checksum, then a consistent ack with the wrong seq
    it = mk_good_ack();
    it.ack_checksum = ~it.ack_checksum;
    send_item(it);
    send_item(mk_ack(8'h80 | {7'b0, seq_now}, 4'd5, 8'h3C));
    send_item(mk_ack({7'b0, seq_now}, 4'hF, 8'hFF));
    // a full chunk goes out without the last flag
    for (i = 0; i < CHUNK_BYTES; i++) begin
      it = rand_item(REQ_DATA);
      it.data_last = 1'b0;
      send_item(it);
    end
    write_reg(REG_TIMEOUT_TICKS, 16'd1);
    send_item(rand_item(REQ_TICK));
    write_reg(REG_TIMEOUT_TICKS, 16'd0);
    send_item(rand_item(REQ_TICK));
    send_item(mk_good_ack());
    // eof with a byte pending sends the partial chunk
    it = rand_item(REQ_DATA);
    it.data_last = 1'b0;
    send_item(it);
    send_item(rand_item(REQ_EOF));
    send_item(mk_good_ack());
    write_reg(REG_EOF_ATTEMPTS, 16'd0);
  endtask

  task automatic test_short_timeout();
    write_reg(REG_TIMEOUT_TICKS, 16'($urandom_range(2, 6)));
    run_traffic(120);
  endtask

  task automatic test_long_timeout();
    write_reg(REG_TIMEOUT_TICKS, 16'hFFFF);
    run_traffic(80);
  endtask

  task automatic test_backpressure();
    req_item_t it;
    int        i;
    // no request on offer while waiting for the receiver to hold off
    req.valid <= 1'b0;
    rsp_hold = 80;
    while (!rsp_holding) @(posedge clk);
    req_steady = 1'b1;
    for (i = 0; i < CHUNK_BYTES; i++) begin
      it = rand_item(REQ_DATA);
      it.data_last = 1'b0;
      send_item(it);
    end
    for (i = 0; i < 4; i++) send_item(rand_item(REQ_DATA));
    send_item(mk_bad_ack());
    req_steady = 1'b0;
    // hold the sender until the stalled burst has fully drained
    drain_results();
    send_item(mk_good_ack());
  endtask

  task automatic test_every_tick();
    // upper data bits are dropped by the 2-bit register
    write_reg(REG_EOF_ATTEMPTS, 16'hFFFF);
    write_reg(REG_TIMEOUT_TICKS, 16'd1);
    run_traffic(100);
  endtask

  task automatic test_end_of_file();
    write_reg(REG_EOF_ATTEMPTS, 16'($urandom_range(0, 3)));
    write_reg(REG_TIMEOUT_TICKS, 16'($urandom_range(1, 3)));
    send_item(rand_item(REQ_EOF));
    exercise_wait(PH_WAIT_EOF);
    // finished: data is rejected, the rest is dropped
    repeat (8) send_item(rand_item(2'($urandom)));
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string msg);
    if (errors < 40) $display("%0t ns  mismatch: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want)
      report_mismatch($sformatf("%s expected 0x%02h, got 0x%02h", name, want, got));
  endtask

  always @(posedge clk) begin
    beat_t want;
    if (!rst && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      if (beats_due.size() == 0) begin
        report_mismatch($sformatf("beat of kind %0d with nothing expected", rsp.out_kind));
      end else begin
        want = beats_due.pop_front();
        check_field("out_kind", {5'b0, want.kind}, {5'b0, rsp.out_kind});
        check_field("out_seq", {7'b0, want.seq}, {7'b0, rsp.out_seq});
        check_field("out_len", {4'b0, want.len}, {4'b0, rsp.out_len});
        check_field("out_checksum", want.cks, rsp.out_checksum);
        check_field("out_byte", want.data, rsp.out_byte);
        check_field("out_last", {7'b0, want.last}, {7'b0, rsp.out_last});
      end
    end
  end

  // result receiver: random stalls, steady stretches and long holds on request
  initial begin
    int stall;
    forever begin
      if (rsp_hold > 0) begin
        rsp.ready <= 1'b0;
        rsp_holding = 1'b1;
        repeat (rsp_hold) @(posedge clk);
        rsp_hold = 0;
        rsp_holding = 1'b0;
      end else if (rsp_steady) begin
        rsp.ready <= 1'b1;
        @(posedge clk);
      end else begin
        rsp.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        stall = pick_gap();
        if (stall > 0) begin
          rsp.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  // watchdog: too long without any beat on any channel
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_CYCLES) begin
      @(posedge clk);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("** alternating_bit_sender: FAILED **");
    $finish;
  end

  initial begin
    req.valid           <= 1'b0;
    req.req_type        <= REQ_DATA;
    req.data_byte       <= 8'h00;
    req.data_last       <= 1'b0;
    req.ack_seq         <= 8'h00;
    req.ack_len         <= 4'h0;
    req.ack_payload_xor <= 8'h00;
    req.ack_checksum    <= 8'h00;
    cfg.valid           <= 1'b0;
    cfg.index           <= REG_TIMEOUT_TICKS;
    cfg.data            <= 16'h0000;

    fill_count   = '0;
    fill_xor     = '0;
    seq_now      = 1'b0;
    ph           = PH_FILL;
    ticks_waited = '0;
    eof_sends    = '0;
    cfg_timeout  = TIMEOUT_RESET;
    cfg_attempts = ATTEMPTS_RESET;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_short_timeout();
    test_long_timeout();
    test_backpressure();
    test_every_tick();
    test_end_of_file();

    drain_results();
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("** alternating_bit_sender: PASSED **");
    else
      $display("** alternating_bit_sender: FAILED **");
    $finish;
  end

endmodule
